// ===== hdl/nlms_pkg.sv =====
// Package for the NLMS adaptive noise canceller.
// Holds sizes, register indexes and the controller/datapath command and status types.
// No dependencies.
package nlms_pkg;

  localparam int MAX_TAPS       = 256;
  localparam int SAMPLE_BITS    = 16;
  localparam int MIN_TAPS       = 8;
  localparam int RESET_TAPS     = 64;

  localparam int ADDR_BITS      = $clog2(MAX_TAPS);
  localparam int CNT_BITS       = ADDR_BITS + 1;
  localparam int TAP_FIELD_BITS = 9;
  localparam int STEP_BITS      = 16;
  localparam int REG_BITS       = 32;
  localparam int WEIGHT_BITS    = 32;
  localparam int ACC_BITS       = 48;

  localparam int ENERGY_BITS    = 2 * SAMPLE_BITS + CNT_BITS;
  localparam int GAIN_BITS      = 64 - SAMPLE_BITS;
  localparam int DIV_SHIFT      = SAMPLE_BITS + 13;
  localparam int NUM_BITS       = STEP_BITS + SAMPLE_BITS;
  localparam int DVD_BITS       = NUM_BITS + DIV_SHIFT;
  localparam int DIV_CNT_BITS   = $clog2(DVD_BITS);
  localparam int CTR_BITS       = (CNT_BITS > DIV_CNT_BITS) ? CNT_BITS : DIV_CNT_BITS;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REGULARIZER  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FREEZE_ADAPT = 3'd3;

  typedef struct packed {
    logic                 clear_wr;
    logic [ADDR_BITS-1:0] clear_addr;
    logic                 in_ready;
    logic                 p1_issue;
    logic                 p2_issue;
    logic [ADDR_BITS-1:0] rd_widx;
    logic                 est_load;
    logic                 div_start;
    logic                 div_step;
    logic                 out_load;
    logic                 pos_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                tap_wr;
    logic                in_fire;
    logic                pipe_busy;
    logic                adapt;
    logic                out_busy;
    logic [CNT_BITS-1:0] tap_count;
  } dp_status_t;

endpackage

// ===== hdl/nlms_if.sv =====
// Channel interfaces of the NLMS noise canceller: sample input, error output, register writes.
// Depends on nlms_pkg.
interface nlms_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [nlms_pkg::SAMPLE_BITS-1:0]   primary_sample;
  logic signed [nlms_pkg::SAMPLE_BITS-1:0]   reference_sample;
  modport source (output valid, output primary_sample, output reference_sample, input ready);
  modport sink   (input valid, input primary_sample, input reference_sample, output ready);
endinterface

interface nlms_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [nlms_pkg::SAMPLE_BITS-1:0]   error_sample;
  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

interface nlms_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [nlms_pkg::CFG_IDX_BITS-1:0]         index;
  logic [nlms_pkg::CFG_DATA_BITS-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/nlms_adaptive_noise_canceller.sv =====
// Top level of the NLMS adaptive noise canceller: controller plus datapath.
// Depends on nlms_pkg, nlms_if, nlms_ctrl, nlms_datapath.
//
//   channel   direction  carries
//   samples   in         primary_sample, reference_sample
//   errors    out        error_sample
//   cfg       in         index, data (register writes)
//
// An item takes an estimate pass over the history and weight RAMs and, with adaptation, also
// a divide and an update pass over both RAMs; the passes handle one tap per cycle and the
// divider makes one quotient bit per cycle.
// After reset and after each tap_count write a clear sweep runs; samples is not
// ready during it. Register writes are taken every cycle.
// A finished error waits in the output register; the next sample is taken meanwhile.
module nlms_adaptive_noise_canceller (
  input logic        clk,
  input logic        rst,
  nlms_in_if.sink    samples,
  nlms_out_if.source errors,
  nlms_cfg_if.sink   cfg
);
  import nlms_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  nlms_ctrl u_ctrl (
    .clk, .rst, .status, .cmd
  );

  nlms_datapath u_dp (
    .clk, .rst, .samples, .errors, .cfg, .cmd, .status
  );
endmodule

// ===== hdl/nlms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nlms_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/nlms_ctrl.sv =====
// Sequencer of the NLMS noise canceller: clear sweep, estimate pass, divide, update pass.
// Depends on nlms_pkg.
module nlms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  nlms_pkg::dp_status_t status,
  output nlms_pkg::ctrl_cmd_t  cmd
);
  import nlms_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PASS1, S_DRAIN1, S_EST, S_CHECK,
    S_DIV, S_PASS2, S_DRAIN2, S_DONE
  } state_t;

  state_t              state;
  logic [CTR_BITS-1:0] cnt;
  logic [CTR_BITS-1:0] last_tap;

  assign last_tap = CTR_BITS'(status.tap_count) - CTR_BITS'(1);

  always_comb begin
    cmd            = '0;
    cmd.clear_addr = cnt[ADDR_BITS-1:0];
    cmd.rd_widx    = cnt[ADDR_BITS-1:0];
    unique case (state)
      S_CLEAR:  cmd.clear_wr  = 1'b1;
      S_IDLE:   cmd.in_ready  = 1'b1;
      S_PASS1:  cmd.p1_issue  = 1'b1;
      S_DRAIN1: ;
      S_EST:    cmd.est_load  = 1'b1;
      S_CHECK:  cmd.div_start = status.adapt;
      S_DIV:    cmd.div_step  = 1'b1;
      S_PASS2:  cmd.p2_issue  = 1'b1;
      S_DRAIN2: ;
      S_DONE: begin
        cmd.out_load = !status.out_busy;
        cmd.pos_adv  = !status.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else if (status.tap_wr) begin
      // restart the clear sweep on any tap count write
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (cnt == CTR_BITS'(MAX_TAPS - 1)) state <= S_IDLE;
          cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          cnt <= '0;
          if (status.in_fire) state <= S_PASS1;
        end
        S_PASS1: begin
          if (cnt == last_tap) state <= S_DRAIN1;
          cnt <= cnt + 1'b1;
        end
        S_DRAIN1: if (!status.pipe_busy) state <= S_EST;
        S_EST:    state <= S_CHECK;
        S_CHECK: begin
          cnt   <= '0;
          state <= status.adapt ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (cnt == CTR_BITS'(DVD_BITS - 1)) begin
            state <= S_PASS2;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PASS2: begin
          if (cnt == last_tap) state <= S_DRAIN2;
          cnt <= cnt + 1'b1;
        end
        S_DRAIN2: if (!status.pipe_busy) state <= S_DONE;
        S_DONE:   if (!status.out_busy) state <= S_IDLE;
        default:  state <= S_CLEAR;
      endcase
    end
  end
endmodule

// ===== hdl/nlms_datapath.sv =====
// Datapath of the NLMS noise canceller: registers, history and weight RAMs, MAC pipeline,
// shift-subtract divider, weight update and output register. Depends on nlms_pkg, nlms_ram.
module nlms_datapath (
  input  logic                 clk,
  input  logic                 rst,
  nlms_in_if.sink              samples,
  nlms_out_if.source           errors,
  nlms_cfg_if.sink             cfg,
  input  nlms_pkg::ctrl_cmd_t  cmd,
  output nlms_pkg::dp_status_t status
);
  import nlms_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int PROD_BITS = WEIGHT_BITS + SB;
  localparam int UPD_BITS  = GAIN_BITS + SB;
  localparam int D_BITS    = UPD_BITS - (SB - 1);
  localparam int WSUM_BITS = D_BITS + 2;
  localparam logic signed [ACC_BITS:0] E_MAX = (ACC_BITS+1)'(2**(SB-1) - 1);
  localparam logic signed [ACC_BITS:0] E_MIN = -(ACC_BITS+1)'(2**(SB-1));
  localparam logic signed [WSUM_BITS-1:0] W_MAX =
    WSUM_BITS'((longint'(1) <<< (WEIGHT_BITS-1)) - longint'(1));
  localparam logic signed [WSUM_BITS-1:0] W_MIN =
    -WSUM_BITS'(longint'(1) <<< (WEIGHT_BITS-1));
  localparam logic [DVD_BITS-1:0] GAIN_CAP = DVD_BITS'({GAIN_BITS{1'b1}});

  // configuration registers
  logic [CNT_BITS-1:0]  tap_count;
  logic [STEP_BITS-1:0] step_size;
  logic [REG_BITS-1:0]  regularizer;
  logic                 freeze_adapt;
  logic                 cfg_fire;
  logic [TAP_FIELD_BITS-1:0] tap_field;
  logic [CNT_BITS-1:0]  tap_clamped;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid & cfg.ready;
  assign tap_field = cfg.data[TAP_FIELD_BITS-1:0];

  always_comb begin
    if (tap_field < TAP_FIELD_BITS'(MIN_TAPS)) tap_clamped = CNT_BITS'(MIN_TAPS);
    else if (32'(tap_field) > 32'(MAX_TAPS))   tap_clamped = CNT_BITS'(MAX_TAPS);
    else                                        tap_clamped = CNT_BITS'(tap_field);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= CNT_BITS'(RESET_TAPS);
      step_size    <= STEP_BITS'(6554);
      regularizer  <= REG_BITS'(1024);
      freeze_adapt <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_TAP_COUNT:    tap_count    <= tap_clamped;
        REG_STEP_SIZE:    step_size    <= cfg.data[STEP_BITS-1:0];
        REG_REGULARIZER:  regularizer  <= cfg.data[REG_BITS-1:0];
        REG_FREEZE_ADAPT: freeze_adapt <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // pointers
  logic                 tap_wr;
  logic                 in_fire;
  logic [ADDR_BITS-1:0] pos;
  logic [ADDR_BITS-1:0] p;
  logic [ADDR_BITS-1:0] last_addr;

  assign tap_wr    = cfg_fire && (cfg.index == REG_TAP_COUNT);
  assign in_fire   = samples.valid & cmd.in_ready;
  assign samples.ready = cmd.in_ready;
  assign last_addr = ADDR_BITS'(tap_count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst || tap_wr) begin
      pos <= '0;
    end else if (cmd.pos_adv) begin
      if (CNT_BITS'(pos) + 1'b1 == tap_count) pos <= '0;
      else                                     pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire || cmd.div_start) begin
      p <= pos;
    end else if (cmd.p1_issue || cmd.p2_issue) begin
      p <= (p == '0) ? last_addr : p - 1'b1;
    end
  end

  // memories
  logic                          hist_we;
  logic [ADDR_BITS-1:0]          hist_waddr;
  logic [SB-1:0]                 hist_wdata;
  logic [SB-1:0]                 hist_rdata;
  logic                          w_we;
  logic [ADDR_BITS-1:0]          w_waddr;
  logic [WEIGHT_BITS-1:0]        w_wdata;
  logic [WEIGHT_BITS-1:0]        w_rdata;
  logic signed [WEIGHT_BITS-1:0] w_new;

  logic                          va, va_p2, vb, vb_p2;
  logic [ADDR_BITS-1:0]          widx_a, widx_b;

  assign hist_we    = cmd.clear_wr | in_fire;
  assign hist_waddr = cmd.clear_wr ? cmd.clear_addr : pos;
  assign hist_wdata = cmd.clear_wr ? '0 : samples.reference_sample;
  assign w_we       = cmd.clear_wr | (vb & vb_p2);
  assign w_waddr    = cmd.clear_wr ? cmd.clear_addr : widx_b;
  assign w_wdata    = cmd.clear_wr ? '0 : w_new;

  nlms_ram #(.DEPTH(MAX_TAPS), .WIDTH(SB)) u_hist (
    .clk, .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(p), .rdata(hist_rdata)
  );

  nlms_ram #(.DEPTH(MAX_TAPS), .WIDTH(WEIGHT_BITS)) u_weights (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(cmd.rd_widx), .rdata(w_rdata)
  );

  // MAC / update pipeline
  logic signed [SB-1:0]          rd_x;
  logic signed [WEIGHT_BITS-1:0] rd_w;
  logic [SB-1:0]                 x_mag;
  logic signed [PROD_BITS-1:0]   wx;
  logic signed [2*SB-1:0]        xx;
  logic signed [PROD_BITS-1:0]   prod_b;
  logic [2*SB-1:0]               sq_b;
  logic [UPD_BITS-1:0]           upd_b;
  logic                          neg_b;
  logic signed [WEIGHT_BITS-1:0] w_b;
  logic [GAIN_BITS-1:0]          gain;
  logic signed [SB-1:0]          err;

  assign rd_x  = $signed(hist_rdata);
  assign rd_w  = $signed(w_rdata);
  assign x_mag = rd_x[SB-1] ? SB'(-rd_x) : SB'(rd_x);
  assign wx    = rd_w * rd_x;
  assign xx    = rd_x * rd_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= cmd.p1_issue | cmd.p2_issue;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    va_p2  <= cmd.p2_issue;
    widx_a <= cmd.rd_widx;
    vb_p2  <= va_p2;
    widx_b <= widx_a;
    prod_b <= wx;
    sq_b   <= (2*SB)'(xx);
    upd_b  <= UPD_BITS'(gain) * UPD_BITS'(x_mag);
    neg_b  <= rd_x[SB-1] ^ err[SB-1];
    w_b    <= rd_w;
  end

  logic [D_BITS-1:0]            d_mag;
  logic signed [WSUM_BITS-1:0]  w_sum;

  always_comb begin
    d_mag = D_BITS'(upd_b >> (SB - 1));
    if (neg_b) w_sum = WSUM_BITS'(w_b) - $signed(WSUM_BITS'(d_mag));
    else       w_sum = WSUM_BITS'(w_b) + $signed(WSUM_BITS'(d_mag));
    if (w_sum > W_MAX)      w_new = WEIGHT_BITS'(W_MAX);
    else if (w_sum < W_MIN) w_new = WEIGHT_BITS'(W_MIN);
    else                    w_new = w_sum[WEIGHT_BITS-1:0];
  end

  // accumulators
  logic signed [ACC_BITS-1:0] acc;
  logic [ENERGY_BITS-1:0]     energy;
  logic signed [SB-1:0]       primary;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc     <= '0;
      energy  <= ENERGY_BITS'(regularizer);
      primary <= samples.primary_sample;
    end else if (vb && !vb_p2) begin
      acc    <= acc + ACC_BITS'(prod_b >>> (SB - 1));
      energy <= energy + ENERGY_BITS'(sq_b);
    end
  end

  // estimate and saturated error
  logic signed [ACC_BITS-1:0] acc_rnd;
  logic signed [ACC_BITS-1:0] est;
  logic signed [ACC_BITS:0]   diff;
  logic signed [SB-1:0]       err_sat;

  always_comb begin
    acc_rnd = acc + ACC_BITS'(2**(30 - SB));
    est     = acc_rnd >>> (31 - SB);
    diff    = (ACC_BITS+1)'(primary) - (ACC_BITS+1)'(est);
    if (diff > E_MAX)      err_sat = SB'(E_MAX);
    else if (diff < E_MIN) err_sat = SB'(E_MIN);
    else                   err_sat = diff[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.est_load) err <= err_sat;
  end

  // shift-subtract divider, one quotient bit per cycle
  logic [SB-1:0]          err_mag;
  logic [NUM_BITS-1:0]    numer;
  logic [DVD_BITS-1:0]    dvd;
  logic [DVD_BITS-1:0]    quot;
  logic [ENERGY_BITS-1:0] rem;
  logic [ENERGY_BITS:0]   rem_sh;
  logic                   rem_ge;

  assign err_mag = err[SB-1] ? SB'(-err) : SB'(err);
  assign numer   = NUM_BITS'(step_size) * NUM_BITS'(err_mag);
  assign rem_sh  = {rem, dvd[DVD_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, energy};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= {numer, {DIV_SHIFT{1'b0}}};
      rem  <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      dvd  <= dvd << 1;
      rem  <= rem_ge ? ENERGY_BITS'(rem_sh - {1'b0, energy}) : rem_sh[ENERGY_BITS-1:0];
      quot <= {quot[DVD_BITS-2:0], rem_ge};
    end
    gain <= (quot > GAIN_CAP) ? GAIN_CAP[GAIN_BITS-1:0] : quot[GAIN_BITS-1:0];
  end

  // output register
  logic                 out_valid;
  logic signed [SB-1:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (errors.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= err;
  end

  assign errors.valid        = out_valid;
  assign errors.error_sample = out_data;

  assign status.tap_wr    = tap_wr;
  assign status.in_fire   = in_fire;
  assign status.pipe_busy = va | vb;
  assign status.adapt     = !freeze_adapt && (energy != '0) && (err != '0) && (step_size != '0);
  assign status.out_busy  = out_valid & ~errors.ready;
  assign status.tap_count = tap_count;
endmodule

// ===== hdl/nlms_checker.sv =====
// Port-level checks of the NLMS noise canceller, bound to the top level.
// Depends on nlms_pkg and nlms_adaptive_noise_canceller.
module nlms_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic [nlms_pkg::SAMPLE_BITS-1:0]        out_data,
  input logic                                    cfg_valid,
  input logic                                    cfg_ready,
  input logic [nlms_pkg::CFG_IDX_BITS-1:0]       cfg_index
);
  import nlms_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("samples ready right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second sample taken while one is in work");

  a_tap_write_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_TAP_COUNT) |=> !in_ready)
    else $error("samples ready during clear after tap count write");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled error transfer dropped or changed");
endmodule

bind nlms_adaptive_noise_canceller nlms_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (errors.valid),
  .out_ready (errors.ready),
  .out_data  (errors.error_sample),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_index (cfg.index)
);
